>>> src/gcsa_pkg.sv
// gcsa_pkg: shared types and constants of the gaussian chi-square accumulator
// no dependencies; used by gaussian_chi_square_accumulator

package gcsa_pkg;

    localparam int EXP_TABLE_DEPTH_DEF = 1024;
    localparam int MAX_SETS = 65536;
    localparam int SUM_W = 48;
    localparam int IDX_W = 16;
    localparam int CFG_IDX_W = 8;
    localparam int E_W = 17;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE     = 8'd3;

    typedef struct packed {
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic               active;
        logic               last_of_set;
        logic               new_call;
    } in_t;

    typedef struct packed {
        logic [SUM_W-1:0] chi_square;
        logic [IDX_W-1:0] result_index;
    } out_t;

endpackage

>>> src/gcsa_ram.sv
// gcsa_ram: generic single-write, single-read ram with registered read data
// no dependencies

module gcsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/gaussian_chi_square_accumulator.sv
// gaussian_chi_square_accumulator: scores data points against a gaussian line model
// depends on gcsa_pkg and gcsa_ram
// each input beat runs through the one-bit-per-cycle shared divider
// (20 steps for the gaussian argument, 32 for the residual, each skipped
// when its quotient is out of range); a set end also waits for a free output register
// no new beat is taken while one is in work
// reset: synchronous active low; afterwards all EXP_TABLE_DEPTH+1 entries of the exp
// table are loaded before the first beat is taken

module gaussian_chi_square_accumulator
    import gcsa_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int ROM_DEPTH = EXP_TABLE_DEPTH + 1;
    localparam int AW = $clog2(ROM_DEPTH);
    localparam int CAP = ((MAX_SETS < 65536) ? MAX_SETS : 65536) - 1;
    localparam logic [IDX_W-1:0] CAP_V = IDX_W'(CAP);
    localparam logic [AW-1:0] LAST_ADDR = AW'(EXP_TABLE_DEPTH);

    typedef logic [E_W-1:0] exp_rom_t [ROM_DEPTH];

    // long division for the table build, evaluated at elaboration only
    function automatic longint unsigned udiv_const(input longint unsigned num,
                                                   input longint unsigned den);
        longint unsigned q;
        longint unsigned r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic exp_rom_t build_exp_rom();
        exp_rom_t          rom;
        longint unsigned   w;
        longint unsigned   term;
        longint unsigned   r;
        longint            acc;
        for (int k = 0; k < ROM_DEPTH; k++) begin
            w = udiv_const(longint'(k) << 30, longint'(EXP_TABLE_DEPTH));
            term = 64'd1 << 31;
            acc = 64'sd1 << 31;
            for (int i = 1; i <= 12; i++) begin
                term = udiv_const(term * w, longint'(i) << 31);
                if (i[0]) acc = acc - longint'(term);
                else acc = acc + longint'(term);
            end
            r = (acc < 0) ? 64'd0 : longint'(acc);
            for (int j = 0; j < 5; j++) begin
                r = (r * r + (64'd1 << 30)) >> 31;
            end
            rom[k] = E_W'((r + (64'd1 << 14)) >> 15);
        end
        return rom;
    endfunction

    localparam exp_rom_t EXP_ROM = build_exp_rom();

    typedef enum logic [13:0] {
        S_FILL = 14'b00000000000001,
        S_IDLE = 14'b00000000000010,
        S_PREP = 14'b00000000000100,
        S_DIV1 = 14'b00000000001000,
        S_SQ   = 14'b00000000010000,
        S_IDX  = 14'b00000000100000,
        S_ADDR = 14'b00000001000000,
        S_RD   = 14'b00000010000000,
        S_AMP  = 14'b00000100000000,
        S_PRED = 14'b00001000000000,
        S_LD2  = 14'b00010000000000,
        S_DIV2 = 14'b00100000000000,
        S_NSQ  = 14'b01000000000000,
        S_ACC  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;
    logic signed [31:0] amp_reg, centre_reg;
    logic [30:0] width_reg, noise_reg;
    in_t item_reg, item_next;
    logic [32:0] d_reg, d_next;
    logic [30:0] rem_reg, rem_next, div_reg, div_next;
    logic [31:0] feed_reg, feed_next, quot_reg, quot_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [63:0] prod_reg, prod_next;
    logic hovf_reg, hovf_next, sat_reg, sat_next;
    logic [E_W-1:0] e_reg, e_next;
    logic [SUM_W-1:0] running_sum_reg, running_sum_next;
    logic [IDX_W-1:0] active_count_reg, active_count_next;
    out_t out_reg, out_next;
    logic m_valid_reg, m_valid_next;
    logic [AW-1:0] fill_reg, fill_next;

    logic [30:0] wd_eff, nz_eff;
    logic [31:0] mul_a, mul_b;
    logic [31:0] step_t;
    logic step_ge;
    logic [AW-1:0] ram_raddr;
    logic [E_W-1:0] ram_rdata;
    logic signed [32:0] dx;
    logic [32:0] dx_mag;
    logic [31:0] amp_mag;
    logic [31:0] pm;
    logic signed [33:0] pdiff;
    logic [33:0] pdiff_mag;
    logic [23:0] h_val;
    logic [24:0] idx_full;
    logic [SUM_W-1:0] contrib;
    logic [SUM_W:0] sum_wide;
    logic [SUM_W-1:0] sum_sat;

    assign wd_eff = (width_reg == '0) ? 31'd1 : width_reg;
    assign nz_eff = (noise_reg == '0) ? 31'd1 : noise_reg;
    assign s_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid = m_valid_reg;
    assign m_data = out_reg;

    // shared restoring divider step, one quotient bit per cycle
    assign step_t = {rem_reg, feed_reg[31]};
    assign step_ge = (step_t >= {1'b0, div_reg});

    assign dx = {centre_reg[31], centre_reg} - {item_reg.x_value[31], item_reg.x_value};
    assign dx_mag = dx[32] ? 33'(-dx) : 33'(dx);
    assign amp_mag = amp_reg[31] ? 32'(-{amp_reg[31], amp_reg}) : 32'(amp_reg);
    assign pm = prod_reg[47:16];
    assign pdiff = amp_reg[31]
        ? -({2'b00, pm} + {{2{item_reg.y_value[31]}}, item_reg.y_value})
        : ({2'b00, pm} - {{2{item_reg.y_value[31]}}, item_reg.y_value});
    assign pdiff_mag = pdiff[33] ? 34'(-pdiff) : 34'(pdiff);
    assign h_val = prod_reg[40:17];
    assign idx_full = 25'((prod_reg[43:0] + 44'(1 << 19)) >> 20);
    assign ram_raddr = (idx_full > 25'(EXP_TABLE_DEPTH)) ? LAST_ADDR : idx_full[AW-1:0];
    assign contrib = sat_reg ? SUM_MAX : prod_reg[63:16];
    assign sum_wide = {1'b0, running_sum_reg} + {1'b0, contrib};
    assign sum_sat = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    always_comb begin
        unique case (state_reg)
            S_SQ, S_NSQ: begin
                mul_a = quot_reg;
                mul_b = quot_reg;
            end
            S_IDX: begin
                mul_a = {8'd0, h_val};
                mul_b = 32'(EXP_TABLE_DEPTH);
            end
            S_AMP: begin
                mul_a = amp_mag;
                mul_b = {15'd0, e_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    gcsa_ram #(
        .WIDTH(E_W),
        .DEPTH(ROM_DEPTH)
    ) u_exp_ram (
        .aclk (aclk),
        .we   (state_reg == S_FILL),
        .waddr(fill_reg),
        .wdata(EXP_ROM[fill_reg]),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        item_next = item_reg;
        d_next = d_reg;
        rem_next = rem_reg;
        div_next = div_reg;
        feed_next = feed_reg;
        quot_next = quot_reg;
        cnt_next = cnt_reg;
        prod_next = prod_reg;
        hovf_next = hovf_reg;
        sat_next = sat_reg;
        e_next = e_reg;
        running_sum_next = running_sum_reg;
        active_count_next = active_count_reg;
        out_next = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        fill_next = fill_reg;

        unique case (state_reg)
            S_FILL: begin
                fill_next = fill_reg + 1'b1;
                if (fill_reg == LAST_ADDR) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    if (s_data.new_call) begin
                        running_sum_next = '0;
                        active_count_next = '0;
                    end
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                // |centre-x|/width of 16 or more means the gaussian is zero
                if ({2'b00, dx_mag} >= {wd_eff, 4'd0}) begin
                    e_next = '0;
                    state_next = S_AMP;
                end else begin
                    rem_next = {2'b00, dx_mag[32:4]};
                    feed_next = {dx_mag[3:0], 28'd0};
                    div_next = wd_eff;
                    quot_next = '0;
                    cnt_next = 5'd19;
                    state_next = S_DIV1;
                end
            end
            S_DIV1, S_DIV2: begin
                rem_next = step_ge ? 31'(step_t - {1'b0, div_reg}) : step_t[30:0];
                quot_next = {quot_reg[30:0], step_ge};
                feed_next = {feed_reg[30:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = (state_reg == S_DIV1) ? S_SQ : S_NSQ;
                end
            end
            S_SQ: begin
                prod_next = mul_a * mul_b;
                state_next = S_IDX;
            end
            S_IDX: begin
                hovf_next = (h_val > 24'(1 << 20));
                prod_next = mul_a * mul_b;
                state_next = S_ADDR;
            end
            S_ADDR: begin
                state_next = S_RD;
            end
            S_RD: begin
                e_next = hovf_reg ? '0 : ram_rdata;
                state_next = S_AMP;
            end
            S_AMP: begin
                prod_next = mul_a * mul_b;
                state_next = S_PRED;
            end
            S_PRED: begin
                d_next = pdiff_mag[32:0];
                state_next = S_LD2;
            end
            S_LD2: begin
                // quotient of 2^32 or more saturates the contribution
                if ({14'd0, d_reg} >= {nz_eff, 16'd0}) begin
                    sat_next = 1'b1;
                    state_next = S_ACC;
                end else begin
                    sat_next = 1'b0;
                    rem_next = {14'd0, d_reg[32:16]};
                    feed_next = {d_reg[15:0], 16'd0};
                    div_next = nz_eff;
                    quot_next = '0;
                    cnt_next = 5'd31;
                    state_next = S_DIV2;
                end
            end
            S_NSQ: begin
                prod_next = mul_a * mul_b;
                state_next = S_ACC;
            end
            S_ACC: begin
                if (item_reg.last_of_set) begin
                    if (item_reg.active) begin
                        // hold until the output register is free
                        if (!m_valid_reg || m_ready) begin
                            out_next.chi_square = sum_sat;
                            out_next.result_index = active_count_reg;
                            m_valid_next = 1'b1;
                            if (active_count_reg < CAP_V) begin
                                active_count_next = active_count_reg + 1'b1;
                            end
                            running_sum_next = '0;
                            state_next = S_IDLE;
                        end
                    end else begin
                        running_sum_next = '0;
                        state_next = S_IDLE;
                    end
                end else begin
                    running_sum_next = sum_sat;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_FILL;
            fill_reg <= '0;
            m_valid_reg <= 1'b0;
            running_sum_reg <= '0;
            active_count_reg <= '0;
            amp_reg <= 32'sd65536;
            centre_reg <= '0;
            width_reg <= 31'd65536;
            noise_reg <= 31'd65536;
        end else begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            m_valid_reg <= m_valid_next;
            running_sum_reg <= running_sum_next;
            active_count_reg <= active_count_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_AMPLITUDE: amp_reg <= cfg_data;
                    REG_CENTRE:    centre_reg <= cfg_data;
                    REG_WIDTH:     width_reg <= cfg_data[30:0];
                    REG_NOISE:     noise_reg <= cfg_data[30:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        d_reg <= d_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
        feed_reg <= feed_next;
        quot_reg <= quot_next;
        cnt_reg <= cnt_next;
        prod_reg <= prod_next;
        hovf_reg <= hovf_next;
        sat_reg <= sat_next;
        e_reg <= e_next;
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        active_count_reg <= CAP_V)
        else $error("active set count above cap");

    a_new_call_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.new_call) |=> (running_sum_reg == '0))
        else $error("new call did not clear running sum");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV1 || state_reg == S_DIV2) |-> (rem_reg < div_reg))
        else $error("divider remainder not below divisor");

    a_emit_from_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_ACC))
        else $error("result raised outside accumulate step");
`endif

endmodule

>>> bench/tb.sv
// tb: self-checking bench for gaussian_chi_square_accumulator
// depends on gcsa_pkg and the accumulator rtl; predicts each set score in fixed point
`timescale 1ns / 1ps

module tb;
    import gcsa_pkg::*;

    localparam int DEPTH = EXP_TABLE_DEPTH_DEF;
    localparam int N_RANDOM = 400;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_t                  s_data;
    logic                 m_valid;
    logic                 m_ready;
    out_t                 m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    gaussian_chi_square_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    logic [16:0]      gauss_rom [0:DEPTH];
    logic [31:0]      amp_q, centre_q;
    logic [30:0]      width_q, noise_q;
    logic [SUM_W-1:0] set_sum;
    logic [IDX_W-1:0] set_count;

    out_t   score_q [$];
    int     errors = 0;
    int     scores_seen = 0;
    int     beats_sent = 0;
    bit     calm = 0;

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [16:0] gauss_entry(input longint unsigned k);
        longint unsigned w, term, r;
        longint acc;
        w = (k << 30) / DEPTH;
        term = 64'd1 << 31;
        acc = longint'(64'd1 << 31);
        for (int i = 1; i <= 12; i++) begin
            term = (term * w) / (longint'(i) << 31);
            if (i % 2 == 1) acc -= longint'(term);
            else acc += longint'(term);
        end
        r = acc < 0 ? 0 : longint'(acc);
        for (int i = 0; i < 5; i++) r = (r * r + (64'd1 << 30)) >> 31;
        return 17'((r + (64'd1 << 14)) >> 15);
    endfunction

    function automatic longint unsigned absval(input longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    // one point into the running score; returns 1 when a set score comes out
    function automatic bit score_point(input in_t p, output out_t r);
        longint          amp, pred;
        longint unsigned wd, nz, q, h, idx, e, pm, n, contrib, sum;
        amp = longint'($signed(amp_q));
        wd = width_q == 0 ? 1 : width_q;
        nz = noise_q == 0 ? 1 : noise_q;
        e = 0;
        r = '0;
        if (p.new_call) begin
            set_count = '0;
            set_sum = '0;
        end
        q = (absval(longint'($signed(centre_q)) - longint'(p.x_value)) << 16) / wd;
        if (q < (64'd1 << 20)) begin
            h = (q * q) >> 17;
            if (h <= (64'd1 << 20)) begin
                idx = (h * DEPTH + (64'd1 << 19)) >> 20;
                if (idx > DEPTH) idx = DEPTH;
                e = gauss_rom[idx];
            end
        end
        pm = (absval(amp) * e) >> 16;
        pred = amp < 0 ? -longint'(pm) : longint'(pm);
        n = (absval(pred - longint'(p.y_value)) << 16) / nz;
        contrib = n >= (64'd1 << 32) ? 64'(SUM_MAX) : (n * n) >> 16;
        sum = 64'(set_sum) + contrib;
        set_sum = sum > 64'(SUM_MAX) ? SUM_MAX : sum[SUM_W-1:0];
        if (p.last_of_set) begin
            score_point = p.active;
            if (p.active) begin
                r.chi_square = set_sum;
                r.result_index = set_count;
                if (set_count != 16'hFFFF && 32'(set_count) < MAX_SETS - 1)
                    set_count++;
            end
            set_sum = '0;
        end else begin
            score_point = 0;
        end
    endfunction

    task automatic idle_burst();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    // golden: when has_gold, the score must also equal gold_sum
    task automatic send_point(input in_t p, input bit has_gold = 0,
                              input logic [SUM_W-1:0] gold_sum = '0);
        out_t r;
        idle_burst();
        s_valid <= 1'b1;
        s_data  <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
        if (score_point(p, r)) begin
            if (has_gold && r.chi_square !== gold_sum) begin
                $error("chi_square table: expected %0d actual prediction %0d",
                       gold_sum, r.chi_square);
                errors++;
            end
            score_q.push_back(r);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (score_q.size() != 0 && guard < 200_000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_AMPLITUDE: amp_q = val;
            REG_CENTRE:    centre_q = val;
            REG_WIDTH:     width_q = val[30:0];
            REG_NOISE:     noise_q = val[30:0];
            default: ;
        endcase
    endtask

    task automatic set_model(input logic [31:0] a, c, w, nz);
        drain();
        write_reg(REG_AMPLITUDE, a);
        write_reg(REG_CENTRE, c);
        write_reg(REG_WIDTH, w);
        write_reg(REG_NOISE, nz);
        cfg_valid <= 1'b0;
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!calm) m_ready <= ($urandom_range(0, 3) != 0);
            else m_ready <= 1'b1;
            if (m_valid && m_ready) begin
                if (score_q.size() == 0) begin
                    $error("unexpected beat: chi_square %0d result_index %0d",
                           m_data.chi_square, m_data.result_index);
                    errors++;
                end else begin
                    out_t want;
                    want = score_q.pop_front();
                    scores_seen++;
                    if (m_data.chi_square !== want.chi_square) begin
                        $error("chi_square: expected %0d actual %0d",
                               want.chi_square, m_data.chi_square);
                        errors++;
                    end
                    if (m_data.result_index !== want.result_index) begin
                        $error("result_index: expected %0d actual %0d",
                               want.result_index, m_data.result_index);
                        errors++;
                    end
                end
            end
        end
    end

    typedef struct {
        logic [31:0]      x, y;
        bit               act, last, fresh;
        bit               has_gold;
        logic [SUM_W-1:0] gold;
    } row_t;

    // reset model: amp 1, centre 0, width 1, noise 1
    row_t dir_rows [] = '{
        '{32'h0000_0000, 32'h0001_0000, 1, 1, 1, 1, 48'd0},        // peak hit exactly
        '{32'h0000_0000, 32'h0000_0000, 1, 1, 0, 1, 48'd65536},    // residual of one
        '{32'h7FFF_FFFF, 32'h0000_0000, 1, 1, 0, 1, 48'd0},        // far tail, exp zero
        '{32'h8000_0000, 32'h8000_0000, 1, 1, 0, 1, 48'h4000_0000_0000}, // residual 2^31
        '{32'h8000_0000, 32'h7FFF_FFFF, 1, 0, 0, 0, 48'd0},
        '{32'h0000_8000, 32'h7FFF_FFFF, 1, 1, 0, 0, 48'd0},        // two large residuals
        '{32'h0001_0000, 32'hFFFF_0000, 0, 0, 0, 0, 48'd0},
        '{32'h0002_0000, 32'h0000_4000, 0, 1, 0, 0, 48'd0},        // inactive set end
        '{32'h0000_4000, 32'h0000_C000, 1, 0, 0, 0, 48'd0},
        '{32'h0000_4000, 32'h0000_C000, 1, 1, 0, 0, 48'd0},
        '{32'h0004_0000, 32'h0000_0000, 1, 1, 1, 1, 48'd0},        // new call, index back to 0
        '{32'h0003_FFFF, 32'h0000_0010, 1, 0, 0, 0, 48'd0},
        '{32'hFFFC_0000, 32'hFFFF_FFFF, 1, 1, 0, 0, 48'd0}
    };

    initial begin
        in_t p;
        int  points, active_flag;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        for (int k = 0; k <= DEPTH; k++) gauss_rom[k] = gauss_entry(k);
        amp_q = 32'h0001_0000;
        centre_q = '0;
        width_q = 31'h0001_0000;
        noise_q = 31'h0001_0000;
        set_sum = '0;
        set_count = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            p.x_value = dir_rows[i].x;
            p.y_value = dir_rows[i].y;
            p.active = dir_rows[i].act;
            p.last_of_set = dir_rows[i].last;
            p.new_call = dir_rows[i].fresh;
            send_point(p, dir_rows[i].has_gold, dir_rows[i].gold);
        end

        // zero width and noise act as one lsb; negative amplitude; extremes
        set_model(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        for (int i = 0; i < 3; i++) begin
            p = '{x_value: 32'h7FFF_FFFF - i, y_value: 32'h8000_0000 + i,
                  active: 1, last_of_set: i == 2, new_call: i == 0};
            send_point(p);
        end
        set_model(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        p = '{x_value: 32'h8000_0000, y_value: 32'h7FFF_FFFF,
              active: 1, last_of_set: 1, new_call: 1};
        send_point(p);

        // random sets, model changed between phases
        while (beats_sent < N_RANDOM + 20) begin
            if ($urandom_range(0, 9) == 0) begin
                set_model($urandom, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h40000),
                          $urandom_range(1, 3) == 1 ? $urandom : $urandom_range(1, 32'h40000),
                          $urandom_range(1, 3) == 1 ? $urandom : $urandom_range(1, 32'h40000));
            end
            if (beats_sent > N_RANDOM) calm = 1;
            points = $urandom_range(1, 6);
            active_flag = $urandom_range(0, 4) != 0;
            for (int i = 0; i < points; i++) begin
                p.x_value = $urandom_range(0, 3) == 0 ? $urandom
                          : $signed(centre_q) + $signed(32'($urandom_range(0, 32'h60000)) - 32'h30000);
                p.y_value = $urandom_range(0, 4) == 0 ? $urandom
                          : 32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
                p.active = $urandom_range(0, 9) == 0 ? ~active_flag[0] : active_flag[0];
                p.last_of_set = i == points - 1;
                p.new_call = (i == 0 && $urandom_range(0, 11) == 0) || $urandom_range(0, 60) == 0;
                send_point(p);
            end
            if ($urandom_range(0, 40) == 0) drain();   // hold off until all scores are back
        end
        drain();
        if (score_q.size() != 0) begin
            $error("%0d scores never arrived", score_q.size());
            errors++;
        end
        $display("run covered %0d points and %0d set scores over several model settings",
                 beats_sent, scores_seen);
        if (errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
